FILE: design/rsbw_pkg.sv
// ----------------------------------------------------------------------------
// rsbw_pkg
// Shared types and constants for the rotate/shift bilinear warp block.
// ----------------------------------------------------------------------------
package rsbw_pkg;

    localparam int ADDR_BITS = 6;
    localparam int WGT_BITS  = 8;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] REG_COS    = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_SIN    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_SHIFTX = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_SHIFTY = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_MIRROR = 3'd4;

    typedef struct packed {
        logic [ADDR_BITS-1:0] a00;
        logic [ADDR_BITS-1:0] a10;
        logic [ADDR_BITS-1:0] a01;
        logic [ADDR_BITS-1:0] a11;
        logic [WGT_BITS-1:0]  wx;
        logic [WGT_BITS-1:0]  wy;
        logic                 last;
    } t_tap;

    typedef enum logic [1:0] {
        F_LOAD,
        F_CALC,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_PUSH
    } t_back_state;

endpackage

FILE: design/block_rotate_shift_bilinear_warp.sv
// ----------------------------------------------------------------------------
// block_rotate_shift_bilinear_warp
// Rotates, shifts and mirrors a square block by bilinear interpolation.
// ----------------------------------------------------------------------------
// A block is loaded one sample per cycle while full is low (BLOCK_SIDE
// squared items). After the last sample the block stops accepting items and
// emits the warped block in raster order, paced by the back end's single
// memory read port and shared multipliers; coordinate work in the front end
// overlaps it. Loading of the next block starts once the last pixel has
// been computed.
module block_rotate_shift_bilinear_warp #(
    parameter int BLOCK_SIDE  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [SAMPLE_BITS-1:0]       o_warped_sample,
    output logic                                o_block_done,
    input  logic                                i_cfg_we,
    input  logic [rsbw_pkg::IDX_BITS-1:0]       i_cfg_index,
    input  logic [rsbw_pkg::CFG_BITS-1:0]       i_cfg_data
);
    import rsbw_pkg::*;

    logic signed [15:0]         r_cos, r_sin;
    logic signed [12:0]         r_shx, r_shy;
    logic                       r_mirror;

    logic                       we, back_busy, tq_push, tq_full, tq_empty, tq_pop;
    logic                       back_busy_core;
    logic [ADDR_BITS-1:0]       waddr;
    logic signed [SAMPLE_BITS-1:0] wdata, res;
    t_tap                       tap_in, tap_out;
    logic                       res_push, res_last, oq_full;
    logic [SAMPLE_BITS:0]       oq_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= 16'sd16384;
            r_sin    <= '0;
            r_shx    <= '0;
            r_shy    <= '0;
            r_mirror <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COS:    r_cos    <= i_cfg_data;
                REG_SIN:    r_sin    <= i_cfg_data;
                REG_SHIFTX: r_shx    <= i_cfg_data[12:0];
                REG_SHIFTY: r_shy    <= i_cfg_data[12:0];
                REG_MIRROR: r_mirror <= i_cfg_data[0];
                default:    r_mirror <= r_mirror;
            endcase
        end
    end

    rsbw_front #(.SIDE(BLOCK_SIDE), .SB(SAMPLE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_sample    (i_sample),
        .i_cos       (r_cos),
        .i_sin       (r_sin),
        .i_shx       (r_shx),
        .i_shy       (r_shy),
        .i_mirror    (r_mirror),
        .i_back_busy (back_busy),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_tap       (tap_in),
        .o_tap_push  (tq_push),
        .i_tap_full  (tq_full)
    );

    rsbw_queue #(.WIDTH($bits(t_tap)), .DEPTH(2)) u_tap_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tq_push),
        .i_data  (tap_in),
        .o_full  (tq_full),
        .i_pop   (tq_pop),
        .o_data  (tap_out),
        .o_empty (tq_empty)
    );

    rsbw_back #(.SIDE(BLOCK_SIDE), .SB(SAMPLE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (we),
        .i_waddr     (waddr),
        .i_wdata     (wdata),
        .i_tap       (tap_out),
        .i_tap_empty (tq_empty),
        .o_tap_pop   (tq_pop),
        .o_busy      (back_busy_core),
        .o_res_push  (res_push),
        .o_res       (res),
        .o_res_last  (res_last),
        .i_res_full  (oq_full)
    );

    assign back_busy = back_busy_core || !tq_empty;

    rsbw_queue #(.WIDTH(SAMPLE_BITS + 1), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_last, res}),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_out),
        .o_empty (empty)
    );

    assign o_warped_sample = oq_out[SAMPLE_BITS-1:0];
    assign o_block_done    = oq_out[SAMPLE_BITS];

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> !back_busy)
        else $error("load accepted while block still warping");
    a_tap_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tq_push && tq_full) |=> tq_push && $stable(tap_in))
        else $error("tap item changed while stalled");
    a_res_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && oq_full) |=> res_push)
        else $error("result item dropped on full queue");
`endif
endmodule

FILE: design/rsbw_queue.sv
// ----------------------------------------------------------------------------
// rsbw_queue
// Small synchronous FIFO used between stages and on the result side.
// ----------------------------------------------------------------------------
module rsbw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNTW'(wr) - CNTW'(rd);
        end
    end
endmodule

FILE: design/rsbw_front.sv
// ----------------------------------------------------------------------------
// rsbw_front
// Loads source samples and computes per-pixel tap addresses and weights.
// ----------------------------------------------------------------------------
module rsbw_front #(
    parameter int SIDE = 8,
    parameter int SB   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic signed [SB-1:0]            i_sample,
    input  logic signed [15:0]              i_cos,
    input  logic signed [15:0]              i_sin,
    input  logic signed [12:0]              i_shx,
    input  logic signed [12:0]              i_shy,
    input  logic                            i_mirror,
    input  logic                            i_back_busy,
    output logic                            o_we,
    output logic [rsbw_pkg::ADDR_BITS-1:0]  o_waddr,
    output logic signed [SB-1:0]            o_wdata,
    output rsbw_pkg::t_tap                  o_tap,
    output logic                            o_tap_push,
    input  logic                            i_tap_full
);
    import rsbw_pkg::*;

    localparam int NPIX   = SIDE * SIDE;
    localparam int CW     = (SIDE > 2) ? $clog2(SIDE) : 1;
    localparam int UW     = 24;
    localparam int PRW    = UW + 16;
    localparam int ACW    = PRW + 2;
    localparam int CENTRE = (SIDE - 1) * 8192;

    t_front_state          r_state, n_state;
    logic [ADDR_BITS-1:0]  r_lpos;
    logic [CW-1:0]         r_x, r_y;
    logic [2:0]            r_ph;
    logic signed [PRW-1:0] r_prod;
    logic signed [ACW-1:0] r_accx, r_accy;

    logic signed [UW-1:0]  ux, uy, op_a;
    logic signed [15:0]    op_b;
    logic                  load_acc, last_load, last_pix, tap_acc;
    logic signed [ACW-1:0] rxr, ryr, rxm, px, py, x0, y0;
    logic [CW-1:0]         x0c, x1c, y0c, y1c;

    function automatic logic [CW-1:0] clamp_c(input logic signed [ACW-1:0] v);
        logic [CW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ACW'(SIDE - 1)) begin
            r = CW'(SIDE - 1);
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic [ADDR_BITS-1:0] addr_of(input logic [CW-1:0] yy,
                                                    input logic [CW-1:0] xx);
        return ADDR_BITS'(ADDR_BITS'(yy) * ADDR_BITS'(SIDE) + ADDR_BITS'(xx));
    endfunction

    assign ux = $signed({{(UW-CW-14){1'b0}}, r_x, 14'd0}) - UW'(CENTRE)
              - $signed({{(UW-19){i_shx[12]}}, i_shx, 6'd0});
    assign uy = $signed({{(UW-CW-14){1'b0}}, r_y, 14'd0}) - UW'(CENTRE)
              - $signed({{(UW-19){i_shy[12]}}, i_shy, 6'd0});
    assign op_a = (r_ph == 3'd0 || r_ph == 3'd3) ? ux : uy;
    assign op_b = (r_ph == 3'd0 || r_ph == 3'd2) ? i_cos : i_sin;

    assign last_load = (r_lpos == ADDR_BITS'(NPIX - 1));
    assign last_pix  = (r_x == CW'(SIDE - 1)) && (r_y == CW'(SIDE - 1));
    assign load_acc  = i_push && !o_full;
    assign tap_acc   = o_tap_push && !i_tap_full;

    assign rxr = (r_accx + ACW'(8192)) >>> 14;
    assign ryr = (r_accy + ACW'(8192)) >>> 14;
    assign rxm = i_mirror ? -rxr : rxr;
    assign px  = rxm + ACW'(CENTRE);
    assign py  = ryr + ACW'(CENTRE);
    assign x0  = px >>> 14;
    assign y0  = py >>> 14;
    assign x0c = clamp_c(x0);
    assign x1c = clamp_c(x0 + ACW'(1));
    assign y0c = clamp_c(y0);
    assign y1c = clamp_c(y0 + ACW'(1));

    always_comb begin
        o_tap.a00  = addr_of(y0c, x0c);
        o_tap.a10  = addr_of(y0c, x1c);
        o_tap.a01  = addr_of(y1c, x0c);
        o_tap.a11  = addr_of(y1c, x1c);
        o_tap.wx   = px[13:6];
        o_tap.wy   = py[13:6];
        o_tap.last = last_pix;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_LOAD: if (load_acc && last_load) n_state = F_CALC;
            F_CALC: if (r_ph == 3'd4) n_state = F_PUSH;
            F_PUSH: if (tap_acc) n_state = last_pix ? F_LOAD : F_CALC;
            default: n_state = F_LOAD;
        endcase
    end

    always_comb begin
        o_full     = 1'b1;
        o_tap_push = 1'b0;
        unique case (r_state)
            F_LOAD: o_full = i_back_busy;
            F_CALC: o_full = 1'b1;
            F_PUSH: o_tap_push = 1'b1;
            default: o_full = 1'b1;
        endcase
    end

    assign o_we    = load_acc;
    assign o_waddr = r_lpos;
    assign o_wdata = i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_LOAD;
            r_lpos  <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            if (load_acc) begin
                r_lpos <= last_load ? '0 : r_lpos + 1'b1;
            end
            if (r_state == F_CALC) begin
                r_ph <= r_ph + 1'b1;
            end else begin
                r_ph <= '0;
            end
            if (tap_acc) begin
                if (r_x == CW'(SIDE - 1)) begin
                    r_x <= '0;
                    r_y <= last_pix ? '0 : r_y + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PRW'(op_a * op_b);
        if (r_state == F_CALC) begin
            unique case (r_ph)
                3'd1: r_accx <= ACW'(r_prod);
                3'd2: r_accx <= r_accx + ACW'(r_prod);
                3'd3: r_accy <= ACW'(r_prod);
                3'd4: r_accy <= r_accy - ACW'(r_prod);
                default: r_accx <= r_accx;
            endcase
        end
    end
endmodule

FILE: design/rsbw_back.sv
// ----------------------------------------------------------------------------
// rsbw_back
// Holds the source block, fetches four taps and blends them bilinearly.
// ----------------------------------------------------------------------------
module rsbw_back #(
    parameter int SIDE = 8,
    parameter int SB   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [rsbw_pkg::ADDR_BITS-1:0]  i_waddr,
    input  logic signed [SB-1:0]            i_wdata,
    input  rsbw_pkg::t_tap                  i_tap,
    input  logic                            i_tap_empty,
    output logic                            o_tap_pop,
    output logic                            o_busy,
    output logic                            o_res_push,
    output logic signed [SB-1:0]            o_res,
    output logic                            o_res_last,
    input  logic                            i_res_full
);
    import rsbw_pkg::*;

    localparam int NPIX = SIDE * SIDE;
    localparam int AW   = $clog2(NPIX);
    localparam int MW   = SB + 10;
    localparam int PW2  = MW + 10;
    localparam int SW   = PW2 + 1;

    t_back_state           r_state, n_state;
    t_tap                  r_tap;
    logic [3:0]            r_step;
    logic signed [SB-1:0]  r_mem [NPIX];
    logic signed [SB-1:0]  r_rd;
    logic signed [MW-1:0]  r_prod, r_row0, r_row1;
    logic signed [PW2-1:0] r_p2;
    logic signed [SW-1:0]  r_sum;

    logic [ADDR_BITS-1:0]  raddr;
    logic [8:0]            wxi, wyi, w1;
    logic signed [SW-1:0]  rnd;

    assign wxi = 9'd256 - {1'b0, r_tap.wx};
    assign wyi = 9'd256 - {1'b0, r_tap.wy};
    assign w1  = (r_step == 4'd1 || r_step == 4'd3) ? wxi : {1'b0, r_tap.wx};

    always_comb begin
        unique case (r_step)
            4'd0:    raddr = r_tap.a00;
            4'd1:    raddr = r_tap.a10;
            4'd2:    raddr = r_tap.a01;
            default: raddr = r_tap.a11;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr[AW-1:0]] <= i_wdata;
        end
        r_rd <= r_mem[raddr[AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_tap_empty) n_state = B_RUN;
            B_RUN:  if (r_step == 4'd8) n_state = B_PUSH;
            B_PUSH: if (!i_res_full) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_tap_pop  = 1'b0;
        o_res_push = 1'b0;
        o_busy     = 1'b1;
        unique case (r_state)
            B_IDLE: begin
                o_tap_pop = !i_tap_empty;
                o_busy    = 1'b0;
            end
            B_RUN:  o_busy = 1'b1;
            B_PUSH: o_res_push = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

    assign rnd = (r_sum + SW'(32768)) >>> 16;

    always_comb begin
        if (rnd > SW'((2 ** (SB - 1)) - 1)) begin
            o_res = {1'b0, {(SB-1){1'b1}}};
        end else if (rnd < -SW'(2 ** (SB - 1))) begin
            o_res = {1'b1, {(SB-1){1'b0}}};
        end else begin
            o_res = rnd[SB-1:0];
        end
    end
    assign o_res_last = r_tap.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == B_RUN) ? r_step + 1'b1 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tap_pop) begin
            r_tap <= i_tap;
        end
        if (r_state == B_RUN) begin
            unique case (r_step)
                4'd1, 4'd2, 4'd3: r_prod <= MW'(r_rd * $signed({1'b0, w1}));
                4'd4: begin
                    r_prod <= MW'(r_rd * $signed({1'b0, w1}));
                    r_row1 <= r_prod;
                end
                4'd5: r_row1 <= r_row1 + r_prod;
                4'd6: r_p2 <= PW2'(r_row0 * $signed({1'b0, wyi}));
                4'd7: begin
                    r_sum <= SW'(r_p2);
                    r_p2  <= PW2'(r_row1 * $signed({1'b0, r_tap.wy}));
                end
                4'd8: r_sum <= r_sum + SW'(r_p2);
                default: r_prod <= r_prod;
            endcase
            if (r_step == 4'd2) begin
                r_row0 <= r_prod;
            end else if (r_step == 4'd3) begin
                r_row0 <= r_row0 + r_prod;
            end
        end
    end
endmodule
